@@ rtl/core/psw_pkg.sv @@
// Package for the polar scan to world points block: vector and config types,
// fixed-point widths, register indexes and the CORDIC arctangent table.
// No dependencies.
package psw_pkg;

    // Rotation datapath: x, y carry range * gain in Q.16 plus CORDIC growth.
    localparam int XW = 35;
    localparam int ZW = 33;
    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int MW = 16;
    localparam int OFS_W = 24;
    localparam int OUT_W = 26;
    localparam int FRAC = 30;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // round(2^16 / CORDIC gain)
    localparam logic [RANGE_W-1:0] GAIN_COMP = 16'd39797;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_M00      = 3'd0,
        CFG_M01      = 3'd1,
        CFG_M10      = 3'd2,
        CFG_M11      = 3'd3,
        CFG_OFFSET_X = 3'd4,
        CFG_OFFSET_Y = 3'd5
    } psw_cfg_idx_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } psw_vec_t;

    typedef struct packed {
        logic signed [MW-1:0]    m00;
        logic signed [MW-1:0]    m01;
        logic signed [MW-1:0]    m10;
        logic signed [MW-1:0]    m11;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
    } psw_cfg_t;

endpackage

@@ rtl/core/psw_cordic_cell.sv @@
// One CORDIC micro-rotation with its own pipeline register and handshake.
// Depends on psw_pkg (vector type, arctangent table).
module psw_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psw_pkg::psw_vec_t  in_vec,
    output logic               out_valid,
    input  logic               out_ready,
    output psw_pkg::psw_vec_t  out_vec
);

    logic                            valid_reg;
    logic                            valid_next;
    psw_pkg::psw_vec_t               vec_reg;
    psw_pkg::psw_vec_t               vec_next;
    logic signed [psw_pkg::XW-1:0]   x_in;
    logic signed [psw_pkg::XW-1:0]   y_in;
    logic signed [psw_pkg::ZW-1:0]   z_in;
    logic signed [psw_pkg::XW-1:0]   dx;
    logic signed [psw_pkg::XW-1:0]   dy;
    logic signed [psw_pkg::ZW-1:0]   angle;
    logic                            take;

    assign take     = !valid_reg || out_ready;
    assign in_ready = take;

    assign x_in  = in_vec.x;
    assign y_in  = in_vec.y;
    assign z_in  = in_vec.z;
    assign dx    = y_in >>> STAGE;
    assign dy    = x_in >>> STAGE;
    assign angle = signed'(psw_pkg::ZW'(psw_pkg::ATAN_TAB[STAGE]));

    always_comb
    begin
        if (!z_in[psw_pkg::ZW-1])
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - angle;
        end
        else
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + angle;
        end
    end

    assign valid_next = take ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(vec_reg)))
        else $error("cordic cell dropped or changed a stalled item");
`endif

endmodule

@@ rtl/core/psw_xform.sv @@
// Affine stage: 2x2 matrix multiply, round from Q.30, add offset, saturate.
// Three registered stages with per-stage handshake. Depends on psw_pkg.
module psw_xform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  psw_pkg::psw_vec_t                   in_vec,
    input  psw_pkg::psw_cfg_t                   cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [psw_pkg::OUT_W-1:0]    point_x,
    output logic signed [psw_pkg::OUT_W-1:0]    point_y,
    output logic                                clipped
);

    localparam int PW = psw_pkg::MW + psw_pkg::XW;
    localparam int SW = PW + 1;
    localparam int RW = SW - psw_pkg::FRAC;
    localparam int TW = psw_pkg::OUT_W + 1;
    localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (psw_pkg::FRAC - 1));
    localparam logic signed [psw_pkg::OUT_W-1:0] OUT_MAX =
        {1'b0, {(psw_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [psw_pkg::OUT_W-1:0] OUT_MIN =
        {1'b1, {(psw_pkg::OUT_W-1){1'b0}}};

    logic                    v1_reg, v2_reg, v3_reg;
    logic                    v1_next, v2_next, v3_next;
    logic                    take1, take2, take3;

    logic signed [PW-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [PW-1:0]    p00_next, p01_next, p10_next, p11_next;
    logic signed [SW-1:0]    sum_x, sum_y;
    logic signed [RW-1:0]    sx_reg, sy_reg;
    logic signed [RW-1:0]    sx_next, sy_next;
    logic signed [TW-1:0]    tx, ty;
    logic                    ovf_x, ovf_y;
    logic signed [psw_pkg::OUT_W-1:0] px_next, py_next;
    logic                    clip_next;
    logic signed [psw_pkg::OUT_W-1:0] px_reg, py_reg;
    logic                    clip_reg;

    assign take3 = !v3_reg || out_ready;
    assign take2 = !v2_reg || take3;
    assign take1 = !v1_reg || take2;
    assign in_ready = take1;

    assign v1_next = take1 ? in_valid : v1_reg;
    assign v2_next = take2 ? v1_reg : v2_reg;
    assign v3_next = take3 ? v2_reg : v3_reg;

    // Products
    assign p00_next = cfg.m00 * in_vec.x;
    assign p01_next = cfg.m01 * in_vec.y;
    assign p10_next = cfg.m10 * in_vec.x;
    assign p11_next = cfg.m11 * in_vec.y;

    // Sum and round half up out of Q.30
    assign sum_x   = SW'(p00_reg) + SW'(p01_reg) + HALF;
    assign sum_y   = SW'(p10_reg) + SW'(p11_reg) + HALF;
    assign sx_next = sum_x[SW-1:psw_pkg::FRAC];
    assign sy_next = sum_y[SW-1:psw_pkg::FRAC];

    // Offset and saturate
    assign tx = TW'(sx_reg) + TW'(cfg.offset_x);
    assign ty = TW'(sy_reg) + TW'(cfg.offset_y);
    assign ovf_x = tx[TW-1] != tx[TW-2];
    assign ovf_y = ty[TW-1] != ty[TW-2];

    always_comb
    begin
        if (ovf_x)
        begin
            px_next = tx[TW-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            px_next = tx[psw_pkg::OUT_W-1:0];
        end
        if (ovf_y)
        begin
            py_next = ty[TW-1] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            py_next = ty[psw_pkg::OUT_W-1:0];
        end
        clip_next = ovf_x || ovf_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1 && in_valid)
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
        end
        if (take2 && v1_reg)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (take3 && v2_reg)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = v3_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign clipped   = clip_reg;

`ifndef SYNTHESIS
    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && clip_reg) |-> (px_reg == OUT_MAX || px_reg == OUT_MIN
                                  || py_reg == OUT_MAX || py_reg == OUT_MIN))
        else $error("clipped flag set without a saturated coordinate");
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && !out_ready))
        else $error("affine stage blocked while not full");
`endif

endmodule

@@ rtl/core/polar_scan_to_world_points.sv @@
// Top level: beam entry stage, chain of CORDIC cells, affine output stages
// and the configuration registers. Depends on psw_pkg, psw_cordic_cell, psw_xform.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  beam    | beam_valid beam_ready beam_range beam_angle  | in
//  point   | point_valid point_ready point_x point_y clipped | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | in
//
// One item per cycle sustained while point_ready is high; an item passes the entry
// register, one cell per CORDIC iteration and the three affine stages.
// Every stage holds its item while the next one is full, so a stall on
// point_ready backs up stage by stage; empty stages still fill.
// Reset empties the pipeline and loads the identity matrix, zero offset.
// cfg_ready is always high; indexes past offset_y are dropped.
module polar_scan_to_world_points #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    beam_valid,
    output logic                                    beam_ready,
    input  logic [psw_pkg::RANGE_W-1:0]             beam_range,
    input  logic [psw_pkg::ANGLE_W-1:0]             beam_angle,
    output logic                                    point_valid,
    input  logic                                    point_ready,
    output logic signed [psw_pkg::OUT_W-1:0]        point_x,
    output logic signed [psw_pkg::OUT_W-1:0]        point_y,
    output logic                                    clipped,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [psw_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [psw_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int N = (CORDIC_STAGES > psw_pkg::ATAN_ENTRIES) ?
                       psw_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int PROD_W = 2 * psw_pkg::RANGE_W;

    psw_pkg::psw_cfg_t               cfg_reg;
    psw_pkg::psw_cfg_t               cfg_next;

    logic                            entry_valid_reg;
    logic                            entry_valid_next;
    psw_pkg::psw_vec_t               entry_vec_reg;
    psw_pkg::psw_vec_t               entry_vec_next;
    logic                            entry_take;
    logic [PROD_W-1:0]               x0;
    logic signed [psw_pkg::XW-1:0]   x0_ext;
    logic                            flip;
    logic [31:0]                     phase;

    logic                            chain_valid [N+1];
    logic                            chain_ready [N+1];
    psw_pkg::psw_vec_t               chain_vec   [N+1];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                psw_pkg::CFG_M00:      cfg_next.m00 = cfg_data[psw_pkg::MW-1:0];
                psw_pkg::CFG_M01:      cfg_next.m01 = cfg_data[psw_pkg::MW-1:0];
                psw_pkg::CFG_M10:      cfg_next.m10 = cfg_data[psw_pkg::MW-1:0];
                psw_pkg::CFG_M11:      cfg_next.m11 = cfg_data[psw_pkg::MW-1:0];
                psw_pkg::CFG_OFFSET_X: cfg_next.offset_x = cfg_data[psw_pkg::OFS_W-1:0];
                psw_pkg::CFG_OFFSET_Y: cfg_next.offset_y = cfg_data[psw_pkg::OFS_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.m00      <= 16'sd16384;
            cfg_reg.m01      <= '0;
            cfg_reg.m10      <= '0;
            cfg_reg.m11      <= 16'sd16384;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Entry stage: gain-compensated range and quadrant pre-rotation
    assign entry_take = !entry_valid_reg || chain_ready[0];
    assign beam_ready = entry_take;

    assign x0     = beam_range * psw_pkg::GAIN_COMP;
    assign x0_ext = signed'(psw_pkg::XW'(x0));
    assign flip   = beam_angle[psw_pkg::ANGLE_W-1] ^ beam_angle[psw_pkg::ANGLE_W-2];
    assign phase  = {beam_angle[psw_pkg::ANGLE_W-1] ^ flip,
                     beam_angle[psw_pkg::ANGLE_W-2:0], 16'b0};

    always_comb
    begin
        entry_vec_next.x = flip ? -x0_ext : x0_ext;
        entry_vec_next.y = '0;
        entry_vec_next.z = psw_pkg::ZW'(signed'(phase));
    end

    assign entry_valid_next = entry_take ? beam_valid : entry_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_take && beam_valid)
        begin
            entry_vec_reg <= entry_vec_next;
        end
    end

    assign chain_valid[0] = entry_valid_reg;
    assign chain_vec[0]   = entry_vec_reg;

    // CORDIC cell chain
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        psw_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_vec    (chain_vec[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_vec   (chain_vec[g+1])
        );
    end

    psw_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[N]),
        .in_ready  (chain_ready[N]),
        .in_vec    (chain_vec[N]),
        .cfg       (cfg_reg),
        .out_valid (point_valid),
        .out_ready (point_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .clipped   (clipped)
    );

`ifndef SYNTHESIS
    a_blocked_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !beam_ready |-> (entry_valid_reg && point_valid && !point_ready))
        else $error("beam input blocked while the pipeline has room");
`endif

endmodule
